>>> sv/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

	localparam int TERMS = 24;

	localparam int ANGLE_W = 31;
	localparam int COS_W   = 32;
	localparam int AX_W    = 30;
	localparam int XSQ_W   = 34;
	localparam int RECIP_W = 30;
	localparam int Q_W     = 31;
	localparam int MAG_W   = 33;
	localparam int SUM_W   = 36;
	localparam int ABS_W   = 31;

	localparam int FRAC      = 30;
	localparam int XSQ_SHIFT = 26;
	localparam int Q_SHIFT   = 32;
	localparam int MAG_SHIFT = 28;
	localparam int SQ_SHIFT  = 29;

	localparam longint ONE_Q30 = longint'(1) << FRAC;

	localparam logic signed [ANGLE_W-1:0] PI_Q28 = 31'sd843314856;
	localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(ONE_Q30 / 2);
	localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(ONE_Q30);
	localparam logic [ABS_W-1:0] ONE_ABS = ABS_W'(ONE_Q30);
	localparam logic [COS_W-1:0] COS_ONE = COS_W'(ONE_Q30 << 1);

	// partial state of the series as it moves from cell to cell
	typedef struct packed {
		logic [XSQ_W-1:0]        xsq;
		logic [Q_W-1:0]          q;
		logic [MAG_W-1:0]        mag;
		logic signed [SUM_W-1:0] sum;
	} term_t;

endpackage

>>> sv/cos_squared_taylor_series.sv
`timescale 1ns / 1ps

// cos squared of a signed Q3.28 angle (clamped to plus or minus pi), returned as unsigned
// Q1.31 in [0, 1]. cosine is a Maclaurin series of TERMS terms, one term per cell in a
// chain of TERMS-1 cells behind a two-stage front (clamp, square, first ratio) and ahead
// of a two-stage back (magnitude clamp, square). one request is taken every cycle while
// the output is not stalled; a stalled output holds the chain only as far back as it
// is full.

module cos_squared_taylor_series (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [cst_pkg::ANGLE_W-1:0] angle,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cst_pkg::COS_W-1:0]          cos_sq
);
	import cst_pkg::*;

	term_t link_d [TERMS];
	logic  link_v [TERMS];
	logic  link_r [TERMS];

	cst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (in_valid),
		.stall_up   (in_stall),
		.angle      (angle),
		.valid_out  (link_v[0]),
		.ready_down (link_r[0]),
		.d_out      (link_d[0])
	);

	for (genvar gi = 0; gi < TERMS-1; gi++) begin : g_cell
		// this cell adds term gi+1 and prepares the ratio for term gi+2
		localparam int NXT = gi + 2;
		localparam logic [RECIP_W-1:0] RECIP_NXT =
			RECIP_W'(ONE_Q30 / longint'((2*NXT-1) * (2*NXT)));
		localparam logic NEG = 1'((gi + 1) % 2);

		cst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid_in   (link_v[gi]),
			.ready_up   (link_r[gi]),
			.d_in       (link_d[gi]),
			.recip_next (RECIP_NXT),
			.negate     (NEG),
			.valid_out  (link_v[gi+1]),
			.ready_down (link_r[gi+1]),
			.d_out      (link_d[gi+1])
		);
	end

	cst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (link_v[TERMS-1]),
		.ready_up   (link_r[TERMS-1]),
		.d_in       (link_d[TERMS-1]),
		.valid_out  (out_valid),
		.stall_down (out_stall),
		.cos_sq     (cos_sq)
	);

endmodule

>>> sv/cst_front.sv
`timescale 1ns / 1ps

module cst_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	output logic                          stall_up,
	input  logic signed [cst_pkg::ANGLE_W-1:0] angle,
	output logic                          valid_out,
	input  logic                          ready_down,
	output cst_pkg::term_t                d_out
);
	import cst_pkg::*;

	logic signed [ANGLE_W-1:0] x;
	logic [AX_W-1:0] ax;
	logic [2*AX_W-1:0] sq;
	logic [XSQ_W+RECIP_W-1:0] q_prod;
	logic en_s1, en_s2;
	logic v_s1, v_s2;
	logic [XSQ_W-1:0] xsq_s1;
	term_t d_s2;

	always_comb begin
		priority if (angle > PI_Q28) begin
			x = PI_Q28;
		end else if (angle < -PI_Q28) begin
			x = -PI_Q28;
		end else begin
			x = angle;
		end
	end

	assign ax = x[ANGLE_W-1] ? AX_W'(-x) : AX_W'(x);
	assign sq = (2*AX_W)'(ax) * (2*AX_W)'(ax);
	assign q_prod = (XSQ_W+RECIP_W)'(xsq_s1) * (XSQ_W+RECIP_W)'(RECIP_1);

	// a stage moves when it is empty or its successor moves
	assign en_s2 = !v_s2 || ready_down;
	assign en_s1 = !v_s1 || en_s2;
	assign stall_up = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= valid_in;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && valid_in) begin
			xsq_s1 <= sq[XSQ_SHIFT +: XSQ_W];
		end
		if (en_s2 && v_s1) begin
			d_s2.xsq <= xsq_s1;
			d_s2.q   <= q_prod[Q_SHIFT +: Q_W];
			d_s2.mag <= ONE_MAG;
			d_s2.sum <= SUM_W'(ONE_Q30);
		end
	end

	assign valid_out = v_s2;
	assign d_out = d_s2;

endmodule

>>> sv/cst_cell.sv
`timescale 1ns / 1ps

module cst_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	output logic                          ready_up,
	input  cst_pkg::term_t                d_in,
	input  logic [cst_pkg::RECIP_W-1:0]   recip_next,
	input  logic                          negate,
	output logic                          valid_out,
	input  logic                          ready_down,
	output cst_pkg::term_t                d_out
);
	import cst_pkg::*;

	logic [MAG_W+Q_W-1:0] mag_prod;
	logic [XSQ_W+RECIP_W-1:0] q_prod;
	logic [MAG_W-1:0] mag_n;
	logic signed [SUM_W-1:0] mag_ext;
	logic v_q;
	term_t d_q;

	assign mag_prod = (MAG_W+Q_W)'(d_in.mag) * (MAG_W+Q_W)'(d_in.q);
	assign mag_n = mag_prod[MAG_SHIFT +: MAG_W];
	assign mag_ext = $signed(SUM_W'(mag_n));
	// next cell's ratio is computed here so no cell chains two multiplies
	assign q_prod = (XSQ_W+RECIP_W)'(d_in.xsq) * (XSQ_W+RECIP_W)'(recip_next);

	assign ready_up = !v_q || ready_down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_up) begin
			v_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			d_q.xsq <= d_in.xsq;
			d_q.q   <= q_prod[Q_SHIFT +: Q_W];
			d_q.mag <= mag_n;
			d_q.sum <= negate ? d_in.sum - mag_ext : d_in.sum + mag_ext;
		end
	end

	assign valid_out = v_q;
	assign d_out = d_q;

endmodule

>>> sv/cst_back.sv
`timescale 1ns / 1ps

module cst_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	output logic                        ready_up,
	input  cst_pkg::term_t              d_in,
	output logic                        valid_out,
	input  logic                        stall_down,
	output logic [cst_pkg::COS_W-1:0]   cos_sq
);
	import cst_pkg::*;

	logic signed [SUM_W-1:0] s_neg;
	logic [SUM_W-1:0] s_abs;
	logic [ABS_W-1:0] s_clamp;
	logic [2*ABS_W-1:0] sq;
	logic en_s1, en_s2;
	logic v_s1, v_s2;
	logic [ABS_W-1:0] abs_s1;
	logic [COS_W-1:0] cos_s2;

	assign s_neg = -d_in.sum;
	assign s_abs = d_in.sum[SUM_W-1] ? $unsigned(s_neg) : $unsigned(d_in.sum);
	// a sum past one in magnitude counts as exactly one
	assign s_clamp = (s_abs > SUM_W'(ONE_Q30)) ? ONE_ABS : s_abs[ABS_W-1:0];
	assign sq = (2*ABS_W)'(abs_s1) * (2*ABS_W)'(abs_s1);

	assign en_s2 = !v_s2 || !stall_down;
	assign en_s1 = !v_s1 || en_s2;
	assign ready_up = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= valid_in;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && valid_in) begin
			abs_s1 <= s_clamp;
		end
		if (en_s2 && v_s1) begin
			cos_s2 <= sq[SQ_SHIFT +: COS_W];
		end
	end

	assign valid_out = v_s2;
	assign cos_sq = cos_s2;

endmodule

>>> sv/cst_checker.sv
`timescale 1ns / 1ps

module cst_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic signed [cst_pkg::ANGLE_W-1:0] angle,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [cst_pkg::COS_W-1:0]          cos_sq
);
	import cst_pkg::*;

	// a result waiting on a stall stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cos_sq))
		else $error("stalled result changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cos_sq <= COS_ONE)
		else $error("result above one");

	// with no result held the whole chain can move, so requests are taken
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered out of reset");

endmodule

bind cos_squared_taylor_series cst_checker u_cst_checker (.*);

>>> bench/cos_sq_checker.sv
`timescale 1ns / 1ps

module cos_sq_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [cst_pkg::ANGLE_W-1:0] angle,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [cst_pkg::COS_W-1:0]          cos_sq,
	output int                                 errors,
	output int                                 pending
);

	import cst_pkg::*;

	logic [COS_W-1:0] expected_cos_sq [$];

	// series evaluated in 64-bit integers, truncating at every step like the hardware
	function automatic logic [COS_W-1:0] cos_sq_of(input logic signed [ANGLE_W-1:0] a);
		longint x;
		longint sum;
		longint unsigned ax;
		longint unsigned xsq;
		longint unsigned mag;
		longint unsigned ratio;
		longint unsigned recip;
		longint unsigned s_abs;
		int n;
		x = longint'(a);
		if (x > longint'(PI_Q28)) x = longint'(PI_Q28);
		if (x < -longint'(PI_Q28)) x = -longint'(PI_Q28);
		ax = (x < 0) ? longint'(-x) : x;
		xsq = (ax * ax) >> XSQ_SHIFT;
		mag = ONE_Q30;
		sum = ONE_Q30;
		for (n = 1; n < TERMS; n++) begin
			recip = ONE_Q30 / longint'((2 * n - 1) * (2 * n));
			ratio = (xsq * recip) >> Q_SHIFT;
			mag = (mag * ratio) >> MAG_SHIFT;
			if (n % 2 == 1)
				sum = sum - longint'(mag);
			else
				sum = sum + longint'(mag);
		end
		s_abs = (sum < 0) ? longint'(-sum) : sum;
		if (s_abs > ONE_Q30) s_abs = ONE_Q30;
		return COS_W'((s_abs * s_abs) >> SQ_SHIFT);
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_cos_sq.push_back(cos_sq_of(angle));
			if (out_valid && !out_stall) begin
				if (expected_cos_sq.size() == 0) begin
					$error("cos_sq: result with no request outstanding, got %0d", cos_sq);
					errors = errors + 1;
				end else begin
					if (cos_sq !== expected_cos_sq[0]) begin
						$error("cos_sq: expected %0d, got %0d", expected_cos_sq[0], cos_sq);
						errors = errors + 1;
					end
					void'(expected_cos_sq.pop_front());
				end
			end
			pending = expected_cos_sq.size();
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import cst_pkg::*;

	localparam int PI_I      = 843314856;
	localparam int HALF_PI_I = 421657428;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 40;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic signed [ANGLE_W-1:0]   angle;
	logic                        out_valid;
	logic                        out_stall;
	logic [COS_W-1:0]            cos_sq;
	int                          errors;
	int                          pending;

	bit gaps_on;
	bit hold_req;
	int stall_pct;

	cos_squared_taylor_series uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.angle    (angle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cos_sq   (cos_sq)
	);

	cos_sq_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.angle    (angle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cos_sq   (cos_sq),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls, occasional bursts, one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				out_stall = 1'b1;
				if ($urandom_range(19) == 0)
					repeat ($urandom_range(5, 30)) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
		angle = a;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic sender_gap();
		int r;
		r = $urandom_range(99);
		if (!gaps_on || r < 55)
			return;
		if (r < 90)
			repeat ($urandom_range(1, 3)) @(negedge clk);
		else
			repeat ($urandom_range(8, 40)) @(negedge clk);
	endtask

	function automatic logic signed [ANGLE_W-1:0] rand_angle();
		int pick;
		int base;
		pick = $urandom_range(99);
		if (pick < 70)
			return ANGLE_W'(int'($urandom_range(2 * PI_I)) - PI_I);
		if (pick < 85)
			return ANGLE_W'($urandom);
		case ($urandom_range(4))
			0: base = 0;
			1: base = PI_I;
			2: base = -PI_I;
			3: base = HALF_PI_I;
			default: base = -HALF_PI_I;
		endcase
		return ANGLE_W'(base + int'($urandom_range(64)) - 32);
	endfunction

	task automatic send_random(input int count);
		repeat (count) begin
			send_angle(rand_angle());
			sender_gap();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		angle = '0;
		gaps_on = 1'b0;
		hold_req = 1'b0;
		stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// field extremes, clamping past pi, quarter turns, near-pi sums
		send_angle(31'sd0);
		send_angle(31'sd1);
		send_angle(-31'sd1);
		send_angle(31'sd268435456);
		send_angle(-31'sd268435456);
		send_angle(31'sd421657428);
		send_angle(-31'sd421657428);
		send_angle(31'sd843314855);
		send_angle(31'sd843314856);
		send_angle(-31'sd843314856);
		send_angle(31'sd843314857);
		send_angle(-31'sd843314857);
		send_angle(31'sh3FFFFFFF);
		send_angle(31'sh40000000);
		send_angle(31'sh2AAAAAAA);
		send_angle(31'sh55555555);
		send_angle(31'sd843314000);
		send_angle(-31'sd843314000);
		send_angle(31'sd1000000000);

		// sender waits for the pipe to empty
		while (pending != 0) @(negedge clk);

		// back to back, no idling on either side
		send_random(300);

		// long output hold while requests keep coming, fills the chain
		hold_req = 1'b1;
		send_random(150);
		while (pending != 0) @(negedge clk);

		gaps_on = 1'b1;
		repeat (7) begin
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 70;
			endcase
			send_random(100);
		end

		stall_pct = 0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending != 0)
			$error("cos_sq: %0d expected results never arrived", pending);

		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
sv/cst_pkg.sv
sv/cst_front.sv
sv/cst_cell.sv
sv/cst_back.sv
sv/cos_squared_taylor_series.sv
sv/cst_checker.sv
bench/cos_sq_checker.sv
bench/tb_top.sv
